/* sv/cia_pkg.sv */
// Package for the composite inertia accumulator: request/result types, action codes,
// index tables for the tensor sequencer and clipping helpers. No dependencies.
`default_nettype none

package cia_pkg;

  localparam int DIV_W = 80;  // numerator magnitude bits for the centre divide
  localparam int ACC_W = 128;

  typedef enum logic [2:0] {
    ACT_ROW0   = 3'd0,
    ACT_ROW1   = 3'd1,
    ACT_ROW2   = 3'd2,
    ACT_DIAG   = 3'd3,
    ACT_OFF    = 3'd4,
    ACT_CENTRE = 3'd5,
    ACT_COMMIT = 3'd6,
    ACT_CLEAR  = 3'd7
  } action_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [47:0] value_a;
    logic signed [47:0] value_b;
    logic signed [47:0] value_c;
  } req_t;

  typedef struct packed {
    logic signed [39:0] total_mass;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic signed [47:0] moment_xx;
    logic signed [47:0] moment_yy;
    logic signed [47:0] moment_zz;
    logic signed [47:0] product_xy;
    logic signed [47:0] product_xz;
    logic signed [47:0] product_yz;
    logic               saturated;
    logic               zero_mass;
  } res_t;

  // rotated tensor entry e = 3*i + j
  localparam logic [1:0] T_ROW [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] T_COL [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  // symmetric 3x3 to packed xx,yy,zz,xy,xz,yz
  localparam logic [2:0] SYM [9] = '{3'd0, 3'd3, 3'd4, 3'd3, 3'd1, 3'd5, 3'd4, 3'd5, 3'd2};
  // packed entry to row/col
  localparam logic [1:0] E_ROW [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] E_COL [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
  // shift term operands: squares P,Q for diagonal, pair P,Q for off-diagonal
  localparam logic [1:0] SH_P [6] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] SH_Q [6] = '{2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2};

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    idx3 = {1'b0, r, 1'b0} + {2'b0, r} + {2'b0, c};
  endfunction

  function automatic logic signed [63:0] clip_to(input logic signed [127:0] v, input int w);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (w - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) clip_to = hi[63:0];
    else if (v < lo) clip_to = lo[63:0];
    else clip_to = v[63:0];
  endfunction

  function automatic logic over(input logic signed [127:0] v, input int w);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (w - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    over = (v > hi) || (v < lo);
  endfunction

endpackage

`default_nettype wire

/* sv/composite_inertia_accumulator.sv */
// Composite inertia accumulator: stages component data and on commit folds it into
// the composite mass, centre and inertia with one shared multiply-accumulate unit.
// Depends on cia_pkg.
`default_nettype none

// Staging and clear requests are taken in ST_IDLE. A commit runs with req_ready low:
// 81 products on the shared 64x17 multiplier, finish steps for each tensor or shift
// entry, and three restoring divides (one quotient bit per cycle) for the centre; a
// commit that leaves zero total mass skips the divides. One result per commit is
// held in an output register until taken; a following commit waits only if that
// register is still full.
module composite_inertia_accumulator
  import cia_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  wire  res_ready,
  output res_t res
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TROT  = 8'b0000_0010,
    ST_SHIFT = 8'b0000_0100,
    ST_INC   = 8'b0000_1000,
    ST_CTR   = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_OUTP  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(128'sd1 <<< (FRACTION_BITS - 1));
  localparam int DCNT_W = $clog2(DIV_W + 1);

  state_t state;

  logic signed [17:0] rot [9];
  logic signed [47:0] ten [6];
  logic signed [31:0] ctr [3];
  logic signed [39:0] mass_sum;
  logic signed [31:0] csum [3];
  logic signed [63:0] rtn [6];

  logic signed [63:0] tm [9];
  logic signed [63:0] sh [6];
  logic signed [47:0] ores [6];
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] hold;
  logic signed [47:0] m;
  logic signed [48:0] sm;
  logic signed [49:0] nm;
  logic vd;
  logic satf;
  logic second;
  logic [3:0] e;
  logic [1:0] k;
  logic [1:0] d;
  logic [1:0] fin;

  logic [DIV_W-1:0] dq;
  logic [48:0] drem;
  logic [DCNT_W-1:0] dcnt;
  logic dneg;

  logic [2:0] e3;
  logic [1:0] e2;
  assign e3 = e[2:0];
  assign e2 = e[1:0];

  // operand select
  logic signed [63:0] opa;
  logic signed [63:0] opb;
  logic msub;
  logic last;
  logic signed [31:0] cv [3];
  logic [1:0] sa;
  logic [1:0] sb;

  always_comb begin
    for (int i = 0; i < 3; i++) cv[i] = second ? csum[i] : ctr[i];
    sa = (e3 < 3'd3 && k == 2'd1) ? SH_Q[e3] : SH_P[e3];
    sb = (e3 < 3'd3) ? sa : SH_Q[e3];
    opa = '0;
    opb = '0;
    msub = 1'b0;
    last = 1'b1;
    case (state)
      ST_TROT: begin
        opa = 64'(rot[idx3(T_ROW[e], k)]);
        opb = 64'(ten[SYM[idx3(k, T_COL[e])]]);
        last = (k == 2'd2);
      end
      ST_SHIFT: begin
        opa = 64'(cv[sa]);
        opb = 64'(cv[sb]);
        msub = (e3 >= 3'd3);
        last = (e3 < 3'd3) ? (k == 2'd1) : 1'b1;
      end
      ST_INC: begin
        if (k == 2'd3) begin
          opa = sh[e3];
          opb = 64'(m);
        end else begin
          opa = tm[idx3(E_ROW[e3], k)];
          opb = 64'(rot[idx3(E_COL[e3], k)]);
        end
        last = (k >= 2'd2);
      end
      ST_CTR: begin
        if (k == 2'd0) begin
          opa = 64'(mass_sum);
          opb = 64'(csum[e2]);
        end else begin
          opa = 64'(sm);
          opb = 64'(ctr[e2]);
        end
        last = (k == 2'd1);
      end
      ST_OUTP: begin
        opa = sh[e3];
        opb = 64'(mass_sum);
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // shared multiplier: one 16-bit digit of opb per cycle while fin is zero
  logic [15:0] digit;
  logic signed [16:0] dig;
  logic signed [80:0] pp;
  logic signed [ACC_W-1:0] ppx;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] resc;

  assign digit = opb[{d, 4'b0000} +: 16];
  assign dig = (d == 2'd3) ? {digit[15], digit} : {1'b0, digit};
  assign pp = opa * dig;
  assign ppx = $signed({{(ACC_W - 81){pp[80]}}, pp}) <<< {d, 4'b0000};
  assign acc_next = msub ? acc - ppx : acc + ppx;
  assign resc = (acc + HALF) >>> FRACTION_BITS;

  // finish arithmetic
  logic signed [ACC_W-1:0] rsum;
  logic signed [63:0] rsum_c;
  logic signed [ACC_W-1:0] ov;
  logic signed [63:0] ov_c;
  logic signed [ACC_W-1:0] qv;
  logic signed [63:0] qv_c;
  logic signed [63:0] nm_c;
  logic [48:0] dmag;
  logic [49:0] dt;
  logic dge;
  logic signed [ACC_W-1:0] anum;
  logic signed [47:0] vin [3];
  logic signed [63:0] rot_c [3];
  logic signed [63:0] ctr_c [3];
  logic signed [48:0] sm_in;

  assign rsum = vd ? ACC_W'(rtn[e3]) - hold : ACC_W'(rtn[e3]) + hold;
  assign rsum_c = clip_to(rsum, 64);
  assign ov = ACC_W'(rtn[e3]) - resc;
  assign ov_c = clip_to(ov, 48);
  assign qv = dneg ? -$signed({{(ACC_W - DIV_W){1'b0}}, dq})
                   : $signed({{(ACC_W - DIV_W){1'b0}}, dq});
  assign qv_c = clip_to(qv, 32);
  assign nm_c = clip_to(ACC_W'(nm), 40);
  assign dmag = 49'(nm[49] ? -nm : nm);
  assign dt = {drem, dq[DIV_W-1]};
  assign dge = (dt >= {1'b0, dmag});
  assign anum = acc[ACC_W-1] ? -acc : acc;
  assign sm_in = (req.value_b != '0) ? -49'(req.value_a) : 49'(req.value_a);

  always_comb begin
    vin[0] = req.value_a;
    vin[1] = req.value_b;
    vin[2] = req.value_c;
    for (int i = 0; i < 3; i++) begin
      rot_c[i] = clip_to(ACC_W'(vin[i]), 18);
      ctr_c[i] = clip_to(ACC_W'(vin[i]), 32);
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < 9; i++) rot[i] <= '0;
      for (int i = 0; i < 6; i++) begin
        ten[i] <= '0;
        rtn[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        ctr[i] <= '0;
        csum[i] <= '0;
      end
      mass_sum <= '0;
      e <= '0;
      k <= '0;
      d <= '0;
      fin <= '0;
      second <= 1'b0;
      satf <= 1'b0;
      dcnt <= '0;
    end else begin
      if (res_valid && res_ready && state != ST_EMIT) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            case (req.action)
              ACT_ROW0: for (int i = 0; i < 3; i++) rot[i] <= rot_c[i][17:0];
              ACT_ROW1: for (int i = 0; i < 3; i++) rot[3 + i] <= rot_c[i][17:0];
              ACT_ROW2: for (int i = 0; i < 3; i++) rot[6 + i] <= rot_c[i][17:0];
              ACT_DIAG: for (int i = 0; i < 3; i++) ten[i] <= vin[i];
              ACT_OFF: for (int i = 0; i < 3; i++) ten[3 + i] <= vin[i];
              ACT_CENTRE: for (int i = 0; i < 3; i++) ctr[i] <= ctr_c[i][31:0];
              ACT_COMMIT: begin
                m <= req.value_a;
                vd <= (req.value_b != '0);
                sm <= sm_in;
                nm <= 50'(mass_sum) + 50'(sm_in);
                satf <= 1'b0;
                second <= 1'b0;
                e <= '0;
                k <= '0;
                d <= '0;
                fin <= '0;
                acc <= '0;
                state <= ST_TROT;
              end
              ACT_CLEAR: begin
                for (int i = 0; i < 9; i++) rot[i] <= '0;
                for (int i = 0; i < 6; i++) begin
                  ten[i] <= '0;
                  rtn[i] <= '0;
                end
                for (int i = 0; i < 3; i++) begin
                  ctr[i] <= '0;
                  csum[i] <= '0;
                end
                mass_sum <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_TROT, ST_SHIFT, ST_INC, ST_CTR, ST_OUTP: begin
          if (fin == 2'd0) begin
            acc <= acc_next;
            d <= d + 2'd1;
            if (d == 2'd3) begin
              if (last) fin <= 2'd1;
              else k <= k + 2'd1;
            end
          end else begin
            case (state)
              ST_TROT: begin
                tm[e] <= resc[63:0];
                acc <= '0;
                k <= '0;
                fin <= '0;
                if (e == 4'd8) begin
                  e <= '0;
                  state <= ST_SHIFT;
                end else begin
                  e <= e + 4'd1;
                end
              end
              ST_SHIFT: begin
                sh[e3] <= resc[63:0];
                acc <= '0;
                k <= '0;
                fin <= '0;
                if (e == 4'd5) begin
                  e <= '0;
                  state <= second ? ST_OUTP : ST_INC;
                end else begin
                  e <= e + 4'd1;
                end
              end
              ST_INC: begin
                if (k == 2'd2) begin
                  hold <= resc;
                  acc <= '0;
                  k <= 2'd3;
                  fin <= '0;
                end else if (fin == 2'd1) begin
                  hold <= hold + resc;
                  fin <= 2'd2;
                end else begin
                  rtn[e3] <= rsum_c;
                  satf <= satf | over(rsum, 64) |
                          ((e == 4'd5 && nm == '0) ? over(ACC_W'(nm), 40) : 1'b0);
                  acc <= '0;
                  k <= '0;
                  fin <= '0;
                  if (e == 4'd5) begin
                    e <= '0;
                    if (nm != '0) begin
                      state <= ST_CTR;
                    end else begin
                      mass_sum <= nm_c[39:0];
                      second <= 1'b1;
                      state <= ST_SHIFT;
                    end
                  end else begin
                    e <= e + 4'd1;
                  end
                end
              end
              ST_CTR: begin
                dq <= anum[DIV_W-1:0];
                dneg <= acc[ACC_W-1] ^ nm[49];
                drem <= '0;
                dcnt <= '0;
                acc <= '0;
                k <= '0;
                fin <= '0;
                state <= ST_DIV;
              end
              ST_OUTP: begin
                ores[e3] <= ov_c[47:0];
                satf <= satf | over(ov, 48);
                acc <= '0;
                fin <= '0;
                if (e == 4'd5) state <= ST_EMIT;
                else e <= e + 4'd1;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DIV: begin
          if (dcnt == DCNT_W'(DIV_W)) begin
            csum[e2] <= qv_c[31:0];
            if (e == 4'd2) begin
              e <= '0;
              mass_sum <= nm_c[39:0];
              satf <= satf | over(qv, 32) | over(ACC_W'(nm), 40);
              second <= 1'b1;
              state <= ST_SHIFT;
            end else begin
              satf <= satf | over(qv, 32);
              e <= e + 4'd1;
              state <= ST_CTR;
            end
          end else begin
            drem <= dge ? 49'(dt - {1'b0, dmag}) : dt[48:0];
            dq <= {dq[DIV_W-2:0], dge};
            dcnt <= dcnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!res_valid || res_ready) begin
            res.total_mass <= mass_sum;
            res.centre_x <= csum[0];
            res.centre_y <= csum[1];
            res.centre_z <= csum[2];
            res.moment_xx <= ores[0];
            res.moment_yy <= ores[1];
            res.moment_zz <= ores[2];
            res.product_xy <= ores[3];
            res.product_xz <= ores[4];
            res.product_yz <= ores[5];
            res.saturated <= satf;
            res.zero_mass <= (mass_sum == '0);
            res_valid <= 1'b1;
            e <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_commit_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.action == ACT_COMMIT |=> !req_ready)
    else $error("commit did not start sequencer");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> nm != '0)
    else $error("divide by zero mass");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.zero_mass == (res.total_mass == '0))
    else $error("zero_mass flag mismatch");

endmodule

`default_nettype wire

/* tb/tb_composite_inertia_accumulator.sv */
// Testbench for the composite inertia accumulator: directed and random component
// sequences with a bit-exact predictor and an in-order scoreboard.
// Depends on cia_pkg and composite_inertia_accumulator.
`default_nettype none

class inertia_scoreboard;
  cia_pkg::res_t pending[$];
  int mismatches;
  int checked;

  function void note_request(cia_pkg::res_t r);
    pending.push_back(r);
  endfunction

  function void check_result(cia_pkg::res_t got);
    cia_pkg::res_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending.pop_front();
    checked++;
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch #%0d", checked);
        $display("  exp mass %0d c %0d %0d %0d sat %b zm %b", exp.total_mass, exp.centre_x,
                 exp.centre_y, exp.centre_z, exp.saturated, exp.zero_mass);
        $display("  got mass %0d c %0d %0d %0d sat %b zm %b", got.total_mass, got.centre_x,
                 got.centre_y, got.centre_z, got.saturated, got.zero_mass);
        $display("  exp I %0d %0d %0d %0d %0d %0d", exp.moment_xx, exp.moment_yy,
                 exp.moment_zz, exp.product_xy, exp.product_xz, exp.product_yz);
        $display("  got I %0d %0d %0d %0d %0d %0d", got.moment_xx, got.moment_yy,
                 got.moment_zz, got.product_xy, got.product_xz, got.product_yz);
      end
    end
  endfunction
endclass

module tb_composite_inertia_accumulator;
  import cia_pkg::*;

  localparam int FB = 16;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  composite_inertia_accumulator dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always #5 clk = ~clk;

  inertia_scoreboard sb = new();

  // predictor state
  logic signed [127:0] rot [9];
  logic signed [127:0] stj [6];
  logic signed [127:0] stc [3];
  logic signed [127:0] msum;
  logic signed [127:0] csum [3];
  logic signed [127:0] refj [6];

  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_commits = 0;
  int n_voids = 0;

  function automatic logic signed [127:0] clip(logic signed [127:0] v, int w, ref bit f);
    logic signed [127:0] hi;
    hi = (128'sd1 <<< (w - 1)) - 1;
    if (v > hi) begin f = 1; return hi; end
    if (v < -hi - 1) begin f = 1; return -hi - 1; end
    return v;
  endfunction

  function automatic logic signed [127:0] rescale(logic signed [127:0] v);
    return (v + (128'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic void shift_of(input logic signed [127:0] c [3],
                                   output logic signed [127:0] s [6]);
    bit d;
    logic signed [127:0] xx, yy, zz;
    xx = c[0] * c[0];
    yy = c[1] * c[1];
    zz = c[2] * c[2];
    s[0] = clip(rescale(yy + zz), 64, d);
    s[1] = clip(rescale(xx + zz), 64, d);
    s[2] = clip(rescale(xx + yy), 64, d);
    s[3] = clip(rescale(-(c[0] * c[1])), 64, d);
    s[4] = clip(rescale(-(c[0] * c[2])), 64, d);
    s[5] = clip(rescale(-(c[1] * c[2])), 64, d);
  endfunction

  function automatic int symi(int r, int c);
    if (r == c) return r;
    if (r + c == 1) return 3;
    if (r + c == 2) return 4;
    return 5;
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < 9; i++) rot[i] = 0;
    for (int i = 0; i < 6; i++) begin stj[i] = 0; refj[i] = 0; end
    for (int i = 0; i < 3; i++) begin stc[i] = 0; csum[i] = 0; end
    msum = 0;
  endfunction

  function automatic res_t fold_component(logic signed [127:0] m, bit is_void);
    res_t r;
    bit sat, d;
    logic signed [127:0] sm, nm, acc, inc, num, v;
    logic signed [127:0] t [3][3];
    logic signed [127:0] sh [6];
    logic signed [127:0] nc [3];
    int er [6] = '{0, 1, 2, 0, 0, 1};
    int ec [6] = '{0, 1, 2, 1, 2, 2};
    sat = 0;
    sm = is_void ? -m : m;
    nm = msum + sm;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot[i * 3 + k] * stj[symi(k, j)];
        t[i][j] = clip(rescale(acc), 64, d);
      end
    shift_of(stc, sh);
    for (int e = 0; e < 6; e++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += t[er[e]][k] * rot[ec[e] * 3 + k];
      inc = rescale(acc) + rescale(sh[e] * m);
      if (is_void) inc = -inc;
      refj[e] = clip(refj[e] + inc, 64, sat);
    end
    if (nm != 0) begin
      for (int i = 0; i < 3; i++) begin
        num = msum * csum[i] + sm * stc[i];
        nc[i] = clip(num / nm, 32, sat);
      end
      for (int i = 0; i < 3; i++) csum[i] = nc[i];
    end
    msum = clip(nm, 40, sat);
    shift_of(csum, sh);
    r.total_mass = msum[39:0];
    r.centre_x = csum[0][31:0];
    r.centre_y = csum[1][31:0];
    r.centre_z = csum[2][31:0];
    v = clip(refj[0] - rescale(sh[0] * msum), 48, sat); r.moment_xx = v[47:0];
    v = clip(refj[1] - rescale(sh[1] * msum), 48, sat); r.moment_yy = v[47:0];
    v = clip(refj[2] - rescale(sh[2] * msum), 48, sat); r.moment_zz = v[47:0];
    v = clip(refj[3] - rescale(sh[3] * msum), 48, sat); r.product_xy = v[47:0];
    v = clip(refj[4] - rescale(sh[4] * msum), 48, sat); r.product_xz = v[47:0];
    v = clip(refj[5] - rescale(sh[5] * msum), 48, sat); r.product_yz = v[47:0];
    r.saturated = sat;
    r.zero_mass = (msum == 0);
    return r;
  endfunction

  function automatic void predict(req_t q);
    logic signed [127:0] a, b, c;
    bit d;
    a = q.value_a;
    b = q.value_b;
    c = q.value_c;
    case (action_t'(q.action))
      ACT_ROW0, ACT_ROW1, ACT_ROW2: begin
        rot[q.action * 3] = clip(a, 18, d);
        rot[q.action * 3 + 1] = clip(b, 18, d);
        rot[q.action * 3 + 2] = clip(c, 18, d);
      end
      ACT_DIAG: begin stj[0] = a; stj[1] = b; stj[2] = c; end
      ACT_OFF: begin stj[3] = a; stj[4] = b; stj[5] = c; end
      ACT_CENTRE: begin
        stc[0] = clip(a, 32, d); stc[1] = clip(b, 32, d); stc[2] = clip(c, 32, d);
      end
      ACT_COMMIT: begin
        sb.note_request(fold_component(a, b != 0));
        n_commits++;
        if (b != 0) n_voids++;
      end
      default: clear_state();
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) predict(req);
      if (res_valid && res_ready) sb.check_result(res);
      if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver with random stalls and an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= !rst && ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic signed [47:0] rand48();
    logic signed [47:0] v;
    case ($urandom_range(5))
      0: v = 48'({$urandom(), $urandom()});
      1: v = $signed(48'($urandom_range(8))) <<< 16;
      2: v = -($signed(48'($urandom_range(8))) <<< 16);
      3: v = $signed(48'($urandom_range(65535)));
      default: v = $signed(48'($urandom_range(2 << 20))) - (1 << 20);
    endcase
    return v;
  endfunction

  // request stays valid after acceptance until the next request or an idle gap
  task automatic send(action_t act, logic signed [47:0] a, logic signed [47:0] b,
                      logic signed [47:0] c);
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    req <= '{act, a, b, c};
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_component(bit well_formed);
    if (!well_formed) begin
      send(action_t'($urandom_range(7)), rand48(), rand48(), rand48());
      return;
    end
    for (int i = 0; i < 3; i++)
      send(action_t'(i), rand48(), rand48(), rand48());
    send(ACT_DIAG, rand48(), rand48(), rand48());
    send(ACT_OFF, rand48(), rand48(), rand48());
    send(ACT_CENTRE, rand48(), rand48(), rand48());
    send(ACT_COMMIT, rand48(), ($urandom_range(3) == 0) ? rand48() : 48'sd0, rand48());
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  localparam logic signed [47:0] MAXV = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] MINV = {1'b1, 47'd0};
  localparam logic signed [47:0] ONE = 48'sd65536;

  initial begin
    clear_state();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: unit component, void removing it, extremes, re-commit, clear
    send(ACT_ROW0, ONE, 0, 0);
    send(ACT_ROW1, 0, ONE, 0);
    send(ACT_ROW2, 0, 0, ONE);
    send(ACT_DIAG, ONE, 2 * ONE, 3 * ONE);
    send(ACT_OFF, -ONE, ONE / 2, 0);
    send(ACT_CENTRE, ONE, -ONE, 2 * ONE);
    send(ACT_COMMIT, 2 * ONE, 0, MAXV);
    send(ACT_COMMIT, 2 * ONE, 1, 0);
    send(ACT_COMMIT, -ONE, 0, 0);
    send(ACT_ROW0, MAXV, MINV, MAXV);
    send(ACT_ROW1, MINV, MAXV, MINV);
    send(ACT_ROW2, MAXV, MAXV, MINV);
    send(ACT_DIAG, MAXV, MINV, MAXV);
    send(ACT_OFF, MINV, MAXV, MINV);
    send(ACT_CENTRE, MAXV, MINV, MAXV);
    send(ACT_COMMIT, MAXV, 0, 0);
    send(ACT_COMMIT, MINV, MINV, MINV);
    send(ACT_COMMIT, 0, -1, 0);
    send(ACT_CLEAR, MAXV, MINV, -1);
    send(ACT_COMMIT, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 67; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 67; end
        3: begin send_idle = 15; recv_stall = 15; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) hold_off = 3000;
      for (int k = 0; k < 47; k++) begin
        if ($urandom_range(9) == 0) send(ACT_CLEAR, rand48(), rand48(), rand48());
        send_component($urandom_range(4) != 0);
      end
      drain();
    end

    repeat (1000) @(negedge clk);
    $display("sent %0d requests, %0d commits (%0d voids), %0d results checked",
             n_sent, n_commits, n_voids, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* sim.f */
sv/cia_pkg.sv
sv/composite_inertia_accumulator.sv
tb/tb_composite_inertia_accumulator.sv
